// ===== src/tkrc_pkg.sv =====
// tkrc_pkg: shared types and default constants for the top-K run count select block.
// No dependencies.
package tkrc_pkg;

  localparam int unsigned TOP_K_DEF      = 5;
  localparam int unsigned KEY_BITS_DEF   = 16;
  localparam int unsigned COUNT_BITS_DEF = 20;
  localparam int unsigned PORT_KEY_W     = 16;

  typedef struct packed {
    logic [PORT_KEY_W-1:0] key;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic [PORT_KEY_W-1:0] top_key;
    logic                  report_end;
  } out_item_t;

  typedef struct packed {
    logic flush;   // a finished run is offered to the slots
    logic clear;   // end of data set: slots return to zero
    logic load;    // report row takes the post-flush slot keys
    logic shift;   // report row moves one cell toward the output
  } cell_ctrl_t;

endpackage

// ===== src/tkrc_cell.sv =====
// tkrc_cell: one top-K slot (count, key) plus one stage of the report shift row.
// Depends on tkrc_pkg.
module tkrc_cell import tkrc_pkg::*; #(
  parameter int unsigned TOP_K      = TOP_K_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned IDX        = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cell_ctrl_t                          ctrl,
  input  logic [COUNT_BITS-1:0]               flush_cnt,
  input  logic [KEY_BITS-1:0]                 flush_key,
  input  logic [TOP_K-1:0][COUNT_BITS-1:0]    all_cnt,
  input  logic [KEY_BITS-1:0]                 rpt_in,
  output logic [COUNT_BITS-1:0]               slot_cnt,
  output logic [KEY_BITS-1:0]                 rpt_out,
  output logic                                repl
);

  logic [COUNT_BITS-1:0] slot_cnt_r, slot_cnt_nxt;
  logic [KEY_BITS-1:0]   slot_key_r, slot_key_nxt;
  logic [KEY_BITS-1:0]   rpt_key_r,  rpt_key_nxt;
  logic                  first_min;
  logic [KEY_BITS-1:0]   post_key;

  // this slot holds the lowest-index minimum count
  always_comb begin
    first_min = 1'b1;
    for (int j = 0; j < int'(TOP_K); j++) begin
      if (j < int'(IDX)) begin
        if (!(all_cnt[j] > slot_cnt_r)) first_min = 1'b0;
      end else if (j > int'(IDX)) begin
        if (all_cnt[j] < slot_cnt_r) first_min = 1'b0;
      end
    end
  end

  assign repl     = ctrl.flush && first_min && (flush_cnt > slot_cnt_r);
  assign post_key = repl ? flush_key : slot_key_r;

  always_comb begin
    slot_cnt_nxt = slot_cnt_r;
    slot_key_nxt = slot_key_r;
    rpt_key_nxt  = rpt_key_r;
    if (ctrl.clear) begin
      slot_cnt_nxt = '0;
      slot_key_nxt = '0;
    end else if (repl) begin
      slot_cnt_nxt = flush_cnt;
      slot_key_nxt = flush_key;
    end
    if (ctrl.load) begin
      rpt_key_nxt = post_key;
    end else if (ctrl.shift) begin
      rpt_key_nxt = rpt_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
      slot_key_r <= '0;
    end else begin
      slot_cnt_r <= slot_cnt_nxt;
      slot_key_r <= slot_key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rpt_key_r <= rpt_key_nxt;
  end

  assign slot_cnt = slot_cnt_r;
  assign rpt_out  = rpt_key_r;

endmodule

// ===== src/top_k_run_count_select_top.sv =====
// Top-K run count select: run tracker, row of TOP_K slot cells, report output.
// Depends on tkrc_pkg and tkrc_cell.
//
// Accepts one key per cycle from a stream grouped by key, measures each run of equal
// keys (saturating count) and, when a run ends, puts it into the first slot holding
// the smallest count if it beats that count. A transaction with last set closes the
// data set: its run is flushed into the slots in the following cycle, the TOP_K slot
// keys are loaded into a shift row, and they leave in slot order, one per cycle while
// out_stall is low, the final one with report_end set; the slots are cleared at the
// same time, so the next data set may start right behind. Items that are not last
// are taken every cycle without pause. A last item is held off only in the cycle
// right after a last item, and while the previous report (TOP_K output transactions)
// is still draining. The first report key follows the tail flush register and the row load.
module top_k_run_count_select_top import tkrc_pkg::*; #(
  parameter int unsigned TOP_K      = TOP_K_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned RC_W = $clog2(TOP_K + 1);

  logic                  run_active_r, run_active_nxt;
  logic [KEY_BITS-1:0]   run_key_r, run_key_nxt;
  logic [COUNT_BITS-1:0] run_cnt_r, run_cnt_nxt;
  logic                  tail_valid_r, tail_valid_nxt;
  logic [KEY_BITS-1:0]   tail_key_r, tail_key_nxt;
  logic [COUNT_BITS-1:0] tail_cnt_r, tail_cnt_nxt;
  logic [RC_W-1:0]       rpt_cnt_r, rpt_cnt_nxt;

  logic                  in_acc, out_acc, rpt_busy, kc_flush;
  logic [31:0]           key_ext, out_ext;
  logic [KEY_BITS-1:0]   in_key;
  logic [COUNT_BITS-1:0] flush_cnt;
  logic [KEY_BITS-1:0]   flush_key;
  cell_ctrl_t            ctrl;

  logic [TOP_K-1:0][COUNT_BITS-1:0] all_cnt;
  logic [TOP_K:0][KEY_BITS-1:0]     rpt_link;
  logic [TOP_K-1:0]                 repl_vec;

  assign key_ext  = 32'(in_data.key);
  assign in_key   = key_ext[KEY_BITS-1:0];
  assign rpt_busy = (rpt_cnt_r != '0);
  assign in_stall = in_data.last && (rpt_busy || tail_valid_r);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = rpt_busy;
  assign out_acc  = out_valid && !out_stall;
  assign kc_flush = in_acc && run_active_r && (in_key != run_key_r);

  always_comb begin
    run_active_nxt = run_active_r;
    run_key_nxt    = run_key_r;
    run_cnt_nxt    = run_cnt_r;
    tail_valid_nxt = 1'b0;
    tail_key_nxt   = tail_key_r;
    tail_cnt_nxt   = tail_cnt_r;
    if (in_acc) begin
      if (!run_active_r || (in_key != run_key_r)) begin
        run_key_nxt = in_key;
        run_cnt_nxt = COUNT_BITS'(1);
      end else if (run_cnt_r != '1) begin
        run_cnt_nxt = run_cnt_r + COUNT_BITS'(1);
      end
      run_active_nxt = !in_data.last;
      if (in_data.last) begin
        tail_valid_nxt = 1'b1;
        tail_key_nxt   = run_key_nxt;
        tail_cnt_nxt   = run_cnt_nxt;
      end
    end
  end

  always_comb begin
    flush_cnt   = tail_valid_r ? tail_cnt_r : run_cnt_r;
    flush_key   = tail_valid_r ? tail_key_r : run_key_r;
    ctrl.flush  = tail_valid_r || kc_flush;
    ctrl.clear  = tail_valid_r;
    ctrl.load   = tail_valid_r;
    ctrl.shift  = out_acc;
    rpt_cnt_nxt = rpt_cnt_r;
    if (tail_valid_r) begin
      rpt_cnt_nxt = RC_W'(TOP_K);
    end else if (out_acc) begin
      rpt_cnt_nxt = rpt_cnt_r - RC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      tail_valid_r <= 1'b0;
      rpt_cnt_r    <= '0;
    end else begin
      run_active_r <= run_active_nxt;
      tail_valid_r <= tail_valid_nxt;
      rpt_cnt_r    <= rpt_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_key_r  <= run_key_nxt;
    run_cnt_r  <= run_cnt_nxt;
    tail_key_r <= tail_key_nxt;
    tail_cnt_r <= tail_cnt_nxt;
  end

  assign rpt_link[TOP_K] = '0;

  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    tkrc_cell #(
      .TOP_K      (TOP_K),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .flush_cnt (flush_cnt),
      .flush_key (flush_key),
      .all_cnt   (all_cnt),
      .rpt_in    (rpt_link[i+1]),
      .slot_cnt  (all_cnt[i]),
      .rpt_out   (rpt_link[i]),
      .repl      (repl_vec[i])
    );
  end

  assign out_ext             = 32'(rpt_link[0]);
  assign out_data.top_key    = out_ext[PORT_KEY_W-1:0];
  assign out_data.report_end = (rpt_cnt_r == RC_W'(1));

  a_one_flush_source: assert property (@(posedge clk) disable iff (!rst_n)
    tail_valid_r |-> !kc_flush)
    else $error("tail flush collides with run-change flush");

  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    tail_valid_r |-> (rpt_cnt_r == '0))
    else $error("report row loaded while still draining");

  a_single_replace: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(repl_vec))
    else $error("more than one slot replaced");

  a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.report_end) |=> (rpt_cnt_r == '0))
    else $error("report continues after report_end");

  a_tail_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last) |=> (tail_valid_r && !run_active_r))
    else $error("last transaction did not close the data set");

endmodule
